FILE: rtl/core/rfd_pkg.sv
// Package for the rectangle fill engine with dirty list.
// Opcodes, result kinds, status codes, register indexes and shared types.
// No dependencies.
`default_nettype none

package rfd_pkg;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_FLUSH = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  localparam logic [1:0] KIND_PIXEL  = 2'd0;
  localparam logic [1:0] KIND_STATUS = 2'd1;
  localparam logic [1:0] KIND_ENTRY  = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_RECT  = 3'd1;
  localparam logic [2:0] ST_BUSY      = 3'd2;
  localparam logic [2:0] ST_IDLE_TICK = 3'd3;
  localparam logic [2:0] ST_BAD_INDEX = 3'd4;

  localparam logic REG_SCREEN_W = 1'b0;
  localparam logic REG_SCREEN_H = 1'b1;

  localparam logic [12:0] SCREEN_W_RESET = 13'd1024;
  localparam logic [12:0] SCREEN_H_RESET = 13'd768;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] rect_left;
    logic [15:0] rect_top;
    logic [15:0] rect_width;
    logic [15:0] rect_height;
    logic [31:0] fill_color;
    logic [3:0]  entry_index;
  } in_item_t;

  typedef struct packed {
    logic push;
    logic flush;
    logic rd;
  } list_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/core/rfd_dirty_list.sv
// Dirty rectangle list: entry memory, fill count and registered readout.
// Depends on rfd_pkg for the list control struct.
`default_nettype none

module rfd_dirty_list #(
  parameter int MAX_RECTS = 16,
  parameter int ENT_W     = 52
) (
  input  wire logic                                          clk,
  input  wire logic                                          rst_n,
  input  wire rfd_pkg::list_ctl_t                            ctl,
  input  wire logic [ENT_W-1:0]                              wr_data,
  input  wire logic [((MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1)-1:0] rd_addr,
  output logic      [$clog2(MAX_RECTS+1)-1:0]                count,
  output logic                                               full,
  output logic      [ENT_W-1:0]                              rd_data
);

  localparam int CntW    = $clog2(MAX_RECTS + 1);
  localparam int RdAddrW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;

  logic [ENT_W-1:0] mem [MAX_RECTS];
  logic [CntW-1:0]  count_r;
  logic [CntW-1:0]  count_nxt;
  logic [ENT_W-1:0] rd_data_r;

  assign full = (count_r >= CntW'(MAX_RECTS));

  always_comb begin
    count_nxt = count_r;
    if (ctl.flush) begin
      count_nxt = '0;
    end else if (ctl.push && !full) begin
      count_nxt = count_r + CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push && !full) begin
      mem[RdAddrW'(count_r)] <= wr_data;
    end
    if (ctl.rd) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign count   = count_r;
  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: rtl/core/rect_fill_with_dirty_list_core.sv
// Rectangle fill engine with clipping and a dirty rectangle list (top level).
// Depends on rfd_pkg and rfd_dirty_list.
`default_nettype none

// One command or tick enters per cycle while the input is not stalled. It passes an input
// register, which holds the transfer, then the result register; the clip, pixel-step and
// list logic sits between them, and dirty list readouts come from a registered memory read
// taken on the same edge as the result register. The input stalls only while both the input
// and result registers hold transfers and the output is stalled. Each tick during a fill
// yields one pixel write, so W x H clipped pixels take W*H ticks, one per cycle without stalls.
module rect_fill_with_dirty_list_core #(
  parameter int MAX_RECTS  = 16,
  parameter int MAX_SCREEN = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [12:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [15:0] in_rect_left,
  input  wire logic [15:0] in_rect_top,
  input  wire logic [15:0] in_rect_width,
  input  wire logic [15:0] in_rect_height,
  input  wire logic [31:0] in_fill_color,
  input  wire logic [3:0]  in_entry_index,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_kind,
  output logic [2:0]       out_status,
  output logic [11:0]      out_x,
  output logic [11:0]      out_y,
  output logic [12:0]      out_width,
  output logic [12:0]      out_height,
  output logic [31:0]      out_color,
  output logic             out_last_pixel,
  output logic             out_dirty_kept,
  output logic [4:0]       out_dirty_total
);

  localparam int DimW    = $clog2(MAX_SCREEN + 1);
  localparam int CfgW    = (DimW > 13) ? DimW : 13;
  localparam int ReqW    = ((DimW > 16) ? DimW : 16) + 1;
  localparam int EntW    = 4 * DimW;
  localparam int CntW    = $clog2(MAX_RECTS + 1);
  localparam int RdAddrW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
  localparam int IdxW    = (CntW > 4) ? CntW : 4;

  logic [12:0] scr_w_r;
  logic [12:0] scr_h_r;

  rfd_pkg::in_item_t s1_r;
  logic              s1_v_r;
  logic              s1_v_nxt;
  logic              move;
  logic              accept;

  logic             busy_r,   busy_nxt;
  logic [DimW-1:0]  org_x_r,  org_x_nxt;
  logic [DimW-1:0]  org_y_r,  org_y_nxt;
  logic [DimW-1:0]  clip_w_r, clip_w_nxt;
  logic [DimW-1:0]  clip_h_r, clip_h_nxt;
  logic [DimW-1:0]  col_r,    col_nxt;
  logic [DimW-1:0]  row_r,    row_nxt;
  logic [31:0]      pen_r,    pen_nxt;

  logic        s2_v_r,      s2_v_nxt;
  logic [1:0]  s2_kind_r,   s2_kind_nxt;
  logic [2:0]  s2_status_r, s2_status_nxt;
  logic [11:0] s2_x_r,      s2_x_nxt;
  logic [11:0] s2_y_r,      s2_y_nxt;
  logic [31:0] s2_color_r,  s2_color_nxt;
  logic        s2_last_r,   s2_last_nxt;
  logic        s2_kept_r,   s2_kept_nxt;
  logic        s2_rd_r,     s2_rd_nxt;

  logic [DimW-1:0] scr_w;
  logic [DimW-1:0] scr_h;
  logic [ReqW-1:0] req_x;
  logic [ReqW-1:0] req_y;
  logic [ReqW-1:0] req_w;
  logic [ReqW-1:0] req_h;
  logic            bad_rect;
  logic [DimW-1:0] fit_w;
  logic [DimW-1:0] fit_h;
  logic [DimW-1:0] px;
  logic [DimW-1:0] py;
  logic            last_row;
  logic            last_col;
  logic            rd_ok;

  rfd_pkg::list_ctl_t list_ctl;
  logic [EntW-1:0]    list_wr_data;
  logic [CntW-1:0]    list_count;
  logic               list_full;
  logic [EntW-1:0]    list_rd_data;

  // Configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_w_r <= rfd_pkg::SCREEN_W_RESET;
      scr_h_r <= rfd_pkg::SCREEN_H_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index[0])
        rfd_pkg::REG_SCREEN_W: scr_w_r <= cfg_wdata;
        rfd_pkg::REG_SCREEN_H: scr_h_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Handshake
  assign move     = s1_v_r && (!s2_v_r || !out_stall);
  assign in_stall = s1_v_r && s2_v_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign s1_v_nxt = accept || (s1_v_r && !move);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= '{opcode:      in_opcode,
                rect_left:   in_rect_left,
                rect_top:    in_rect_top,
                rect_width:  in_rect_width,
                rect_height: in_rect_height,
                fill_color:  in_fill_color,
                entry_index: in_entry_index};
    end
  end

  // Clip and step datapath
  assign scr_w = (CfgW'(scr_w_r) > CfgW'(MAX_SCREEN)) ? DimW'(MAX_SCREEN) : DimW'(scr_w_r);
  assign scr_h = (CfgW'(scr_h_r) > CfgW'(MAX_SCREEN)) ? DimW'(MAX_SCREEN) : DimW'(scr_h_r);

  assign req_x = ReqW'(s1_r.rect_left);
  assign req_y = ReqW'(s1_r.rect_top);
  assign req_w = ReqW'(s1_r.rect_width);
  assign req_h = ReqW'(s1_r.rect_height);

  assign bad_rect = (s1_r.rect_width == '0) || (s1_r.rect_height == '0) ||
                    (req_x >= ReqW'(scr_w)) || (req_y >= ReqW'(scr_h));

  assign fit_w = (req_x + req_w > ReqW'(scr_w)) ? (scr_w - DimW'(s1_r.rect_left))
                                                : DimW'(s1_r.rect_width);
  assign fit_h = (req_y + req_h > ReqW'(scr_h)) ? (scr_h - DimW'(s1_r.rect_top))
                                                : DimW'(s1_r.rect_height);

  assign px       = org_x_r + col_r;
  assign py       = org_y_r + row_r;
  assign last_row = ((DimW + 1)'(row_r) + (DimW + 1)'(1)) >= (DimW + 1)'(clip_h_r);
  assign last_col = ((DimW + 1)'(col_r) + (DimW + 1)'(1)) >= (DimW + 1)'(clip_w_r);

  assign rd_ok = (IdxW'(s1_r.entry_index) < IdxW'(list_count)) &&
                 (IdxW'(s1_r.entry_index) < IdxW'(MAX_RECTS));

  always_comb begin
    busy_nxt      = busy_r;
    org_x_nxt     = org_x_r;
    org_y_nxt     = org_y_r;
    clip_w_nxt    = clip_w_r;
    clip_h_nxt    = clip_h_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    pen_nxt       = pen_r;
    list_ctl      = '0;
    s2_kind_nxt   = s2_kind_r;
    s2_status_nxt = s2_status_r;
    s2_x_nxt      = s2_x_r;
    s2_y_nxt      = s2_y_r;
    s2_color_nxt  = s2_color_r;
    s2_last_nxt   = s2_last_r;
    s2_kept_nxt   = s2_kept_r;
    s2_rd_nxt     = s2_rd_r;
    if (move) begin
      s2_kind_nxt   = rfd_pkg::KIND_STATUS;
      s2_status_nxt = rfd_pkg::ST_OK;
      s2_x_nxt      = '0;
      s2_y_nxt      = '0;
      s2_color_nxt  = '0;
      s2_last_nxt   = 1'b0;
      s2_kept_nxt   = 1'b0;
      s2_rd_nxt     = 1'b0;
      case (s1_r.opcode)
        rfd_pkg::OP_START: begin
          if (bad_rect) begin
            s2_status_nxt = rfd_pkg::ST_BAD_RECT;
          end else if (busy_r) begin
            s2_status_nxt = rfd_pkg::ST_BUSY;
          end else begin
            busy_nxt   = 1'b1;
            org_x_nxt  = DimW'(s1_r.rect_left);
            org_y_nxt  = DimW'(s1_r.rect_top);
            clip_w_nxt = fit_w;
            clip_h_nxt = fit_h;
            col_nxt    = '0;
            row_nxt    = '0;
            pen_nxt    = s1_r.fill_color;
          end
        end
        rfd_pkg::OP_TICK: begin
          if (!busy_r) begin
            s2_status_nxt = rfd_pkg::ST_IDLE_TICK;
          end else begin
            s2_kind_nxt  = rfd_pkg::KIND_PIXEL;
            s2_x_nxt     = 12'(px);
            s2_y_nxt     = 12'(py);
            s2_color_nxt = pen_r;
            if (last_row && last_col) begin
              busy_nxt      = 1'b0;
              col_nxt       = '0;
              row_nxt       = '0;
              list_ctl.push = 1'b1;
              s2_last_nxt   = 1'b1;
              s2_kept_nxt   = !list_full;
            end else if (last_row) begin
              row_nxt = '0;
              col_nxt = col_r + DimW'(1);
            end else begin
              row_nxt = row_r + DimW'(1);
            end
          end
        end
        rfd_pkg::OP_FLUSH: begin
          list_ctl.flush = 1'b1;
        end
        rfd_pkg::OP_READ: begin
          if (rd_ok) begin
            list_ctl.rd = 1'b1;
            s2_kind_nxt = rfd_pkg::KIND_ENTRY;
            s2_rd_nxt   = 1'b1;
          end else begin
            s2_status_nxt = rfd_pkg::ST_BAD_INDEX;
          end
        end
        default: ;
      endcase
    end
  end

  assign list_wr_data = {org_x_r, org_y_r, clip_w_r, clip_h_r};

  rfd_dirty_list #(
    .MAX_RECTS (MAX_RECTS),
    .ENT_W     (EntW)
  ) u_list (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (list_ctl),
    .wr_data (list_wr_data),
    .rd_addr (RdAddrW'(s1_r.entry_index)),
    .count   (list_count),
    .full    (list_full),
    .rd_data (list_rd_data)
  );

  assign s2_v_nxt = move || (s2_v_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      org_x_r  <= '0;
      org_y_r  <= '0;
      clip_w_r <= '0;
      clip_h_r <= '0;
      col_r    <= '0;
      row_r    <= '0;
      pen_r    <= '0;
      s2_v_r   <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      org_x_r  <= org_x_nxt;
      org_y_r  <= org_y_nxt;
      clip_w_r <= clip_w_nxt;
      clip_h_r <= clip_h_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      pen_r    <= pen_nxt;
      s2_v_r   <= s2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s2_kind_r   <= s2_kind_nxt;
    s2_status_r <= s2_status_nxt;
    s2_x_r      <= s2_x_nxt;
    s2_y_r      <= s2_y_nxt;
    s2_color_r  <= s2_color_nxt;
    s2_last_r   <= s2_last_nxt;
    s2_kept_r   <= s2_kept_nxt;
    s2_rd_r     <= s2_rd_nxt;
  end

  // Result outputs; entry fields come straight from the registered memory read
  assign out_valid       = s2_v_r;
  assign out_kind        = s2_kind_r;
  assign out_status      = s2_status_r;
  assign out_x           = s2_rd_r ? 12'(list_rd_data[4*DimW-1:3*DimW]) : s2_x_r;
  assign out_y           = s2_rd_r ? 12'(list_rd_data[3*DimW-1:2*DimW]) : s2_y_r;
  assign out_width       = s2_rd_r ? 13'(list_rd_data[2*DimW-1:DimW]) : 13'd0;
  assign out_height      = s2_rd_r ? 13'(list_rd_data[DimW-1:0]) : 13'd0;
  assign out_color       = s2_color_r;
  assign out_last_pixel  = s2_last_r;
  assign out_dirty_kept  = s2_kept_r;
  assign out_dirty_total = 5'(list_count);

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    list_count <= CntW'(MAX_RECTS))
    else $error("dirty list count above capacity");

  a_busy_size: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (clip_w_r != '0) && (clip_h_r != '0))
    else $error("busy with an empty clipped rectangle");

  a_last_idles: assert property (@(posedge clk) disable iff (!rst_n)
    (move && s1_r.opcode == rfd_pkg::OP_TICK && busy_r && last_row && last_col)
      |=> !busy_r && out_last_pixel)
    else $error("final pixel did not end the fill");

  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_pixel) |-> out_kind == rfd_pkg::KIND_PIXEL)
    else $error("last pixel flag on a non-pixel result");
`endif

endmodule

`default_nettype wire
